// ----- src/kcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kcd_pkg;

  localparam int unsigned TableLen = 58;

  localparam logic [7:0] ScanPrefix   = 8'hE0;
  localparam logic [6:0] KeyLShift    = 7'h2A;
  localparam logic [6:0] KeyRShift    = 7'h36;
  localparam logic [6:0] KeyCtrl      = 7'h1D;
  localparam logic [6:0] KeyAlt       = 7'h38;
  localparam logic [6:0] KeyCapsLock  = 7'h3A;
  localparam logic [6:0] KeyC         = 7'h2E;
  localparam logic [6:0] KeyEnter     = 7'h1C;
  localparam logic [6:0] KeyBackspace = 7'h0E;
  localparam logic [6:0] KeyTab       = 7'h0F;

  localparam logic [7:0] ChEtx        = 8'h03;
  localparam logic [7:0] ChLineFeed   = 8'h0A;
  localparam logic [7:0] ChBackspace  = 8'h08;
  localparam logic [7:0] ChTab        = 8'h09;

  localparam logic [7:0] EnPlain [TableLen] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  localparam logic [7:0] EnShift [TableLen] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  localparam logic [7:0] RuPlain [TableLen] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'hA9, 8'hE6, 8'hE3, 8'hAA, 8'hA5, 8'hAD, 8'hA3, 8'hE8,
    8'hE9, 8'hA7, 8'hE5, 8'hEA, 8'h0A, 8'h00, 8'hE4, 8'hEB,
    8'hA2, 8'hA0, 8'hAF, 8'hE0, 8'hAE, 8'hAB, 8'hA4, 8'hA6,
    8'hED, 8'hF1, 8'h00, 8'h5C, 8'hEF, 8'hE7, 8'hE1, 8'hAC,
    8'hA8, 8'hE2, 8'hEC, 8'hA1, 8'hEE, 8'h2E, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  typedef struct packed {
    logic shift;
    logic caps;
    logic ctrl;
    logic russian;
  } kcd_mods_t;

  typedef struct packed {
    logic       caps_on;
    logic       layout_russian;
    logic [7:0] char_code;
    logic       char_valid;
  } kcd_result_t;

endpackage

`default_nettype wire

// ----- src/kcd_char_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcd_char_map import kcd_pkg::*; (
  input  wire logic [6:0] code_i,
  input  kcd_mods_t       mods_i,
  output logic            char_valid_o,
  output logic [7:0]      char_code_o
);

  logic       in_table;
  logic       en_letter;
  logic       upper;
  logic [5:0] idx;
  logic [7:0] ru_v;
  logic [7:0] mapped;
  logic       keep;

  assign in_table  = code_i < 7'(TableLen);
  assign idx       = in_table ? code_i[5:0] : 6'd0;
  assign en_letter = (code_i >= 7'h10 && code_i <= 7'h19) ||
                     (code_i >= 7'h1E && code_i <= 7'h26) ||
                     (code_i >= 7'h2C && code_i <= 7'h32);
  assign upper     = mods_i.shift ^ mods_i.caps;
  assign ru_v      = RuPlain[idx];

  always_comb begin
    mapped = 8'h00;
    if (in_table) begin
      if (!mods_i.russian) begin
        if (en_letter ? upper : mods_i.shift) begin
          mapped = EnShift[idx];
        end else begin
          mapped = EnPlain[idx];
        end
      end else if (!upper) begin
        mapped = ru_v;
      end else if (ru_v == 8'hF1) begin
        mapped = 8'hF0;
      end else if (ru_v >= 8'hA0 && ru_v <= 8'hAF) begin
        mapped = ru_v - 8'h20;
      end else if (ru_v >= 8'hE0 && ru_v <= 8'hEF) begin
        mapped = ru_v - 8'h50;
      end else begin
        mapped = ru_v;
      end
    end
  end

  assign keep = (mapped >= 8'h20 && mapped <= 8'h7E) ||
                (mods_i.russian && ((mapped >= 8'h80 && mapped <= 8'hAF) ||
                                    (mapped >= 8'hE0 && mapped <= 8'hF1)));

  always_comb begin
    char_valid_o = 1'b1;
    char_code_o  = mapped;
    if (mods_i.ctrl && code_i == KeyC) begin
      char_code_o = ChEtx;
    end else if (code_i == KeyEnter) begin
      char_code_o = ChLineFeed;
    end else if (code_i == KeyBackspace) begin
      char_code_o = ChBackspace;
    end else if (code_i == KeyTab) begin
      char_code_o = ChTab;
    end else if (!keep) begin
      char_valid_o = 1'b0;
      char_code_o  = 8'h00;
    end
  end

endmodule

`default_nettype wire

// ----- src/keyboard_scancode_to_char_decoder_top.sv -----
// Channel  Dir  Payload (tdata, lowest bit first)
// s_axis   in   [7:0] scan_byte
// m_axis   out  [0] char_valid, [8:1] char_code, [9] layout_russian, [10] caps_on, [15:11] 0
//
// Each accepted scan byte yields one result beat, registered and presented in the cycle after it is accepted.
// A byte is decoded and all key state is updated in the cycle it is accepted.
// One byte per cycle is sustained; the single output register stalls input only
// while a result waits and m_axis_tready is low.
// Reset clears all modifier, lock and layout state and the held-key map.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_to_char_decoder_top import kcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // char_valid, char_code, layout_russian, caps_on
);

  logic         prefix_q, prefix_d;
  logic         shift_q, shift_d;
  logic         ctrl_q, ctrl_d;
  logic         alt_q, alt_d;
  logic         caps_q, caps_d;
  logic         russian_q, russian_d;
  logic         latch_q, latch_d;
  logic [127:0] held_q, held_d;
  logic         out_valid_q, out_valid_d;
  kcd_result_t  res_q, res_d;

  logic       accept;
  logic [6:0] code;
  logic       released;
  logic       map_valid;
  logic [7:0] map_code;
  logic       emit_char;
  kcd_mods_t  mods;

  assign code     = s_axis_tdata[6:0];
  assign released = s_axis_tdata[7];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign mods = '{shift: shift_q, caps: caps_q, ctrl: ctrl_q, russian: russian_q};

  kcd_char_map u_char_map (
    .code_i       (code),
    .mods_i       (mods),
    .char_valid_o (map_valid),
    .char_code_o  (map_code)
  );

  always_comb begin
    logic chord;
    chord     = 1'b0;
    prefix_d  = prefix_q;
    shift_d   = shift_q;
    ctrl_d    = ctrl_q;
    alt_d     = alt_q;
    caps_d    = caps_q;
    russian_d = russian_q;
    latch_d   = latch_q;
    held_d    = held_q;
    emit_char = 1'b0;
    if (s_axis_tdata == ScanPrefix) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if (code == KeyCtrl) begin
        ctrl_d = !released;
      end else if (code == KeyAlt) begin
        alt_d = !released;
        chord = 1'b1;
      end
    end else if (code == KeyLShift || code == KeyRShift) begin
      shift_d = !released;
      chord   = 1'b1;
    end else if (code == KeyCtrl) begin
      ctrl_d = !released;
    end else if (code == KeyAlt) begin
      alt_d = !released;
      chord = 1'b1;
    end else if (released) begin
      held_d[code] = 1'b0;
    end else if (!held_q[code]) begin
      held_d[code] = 1'b1;
      if (code == KeyCapsLock) begin
        caps_d = !caps_q;
      end else begin
        emit_char = map_valid;
      end
    end
    if (chord) begin
      if (alt_d && shift_d && !latch_q) begin
        russian_d = !russian_q;
        latch_d   = 1'b1;
      end
      if (!alt_d && !shift_d) begin
        latch_d = 1'b0;
      end
    end
  end

  always_comb begin
    res_d.char_valid     = emit_char;
    res_d.char_code      = emit_char ? map_code : 8'h00;
    res_d.layout_russian = russian_d;
    res_d.caps_on        = caps_d;
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= 1'b0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      alt_q       <= 1'b0;
      caps_q      <= 1'b0;
      russian_q   <= 1'b0;
      latch_q     <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        prefix_q  <= prefix_d;
        shift_q   <= shift_d;
        ctrl_q    <= ctrl_d;
        alt_q     <= alt_d;
        caps_q    <= caps_d;
        russian_q <= russian_d;
        latch_q   <= latch_d;
        held_q    <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q};

endmodule

`default_nettype wire

// ----- src/kcd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcd_checker import kcd_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A stalled result beat must hold its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // A beat without a character carries a zero character code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'h00)
    else $error("character code set without char_valid");

  // A prefix byte never produces a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata == ScanPrefix
    |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("prefix byte produced a character");

  // A break code never produces a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[7]
    |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("break code produced a character");

endmodule

bind keyboard_scancode_to_char_decoder_top kcd_checker u_kcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
